// ----- hdl/bpa_pkg.sv -----
package bpa_pkg;

    localparam int MAX_PAGES  = 16384;
    localparam int ADDR_W     = $clog2(2 * MAX_PAGES);
    localparam int TREE_DEPTH = 2 * MAX_PAGES;
    localparam int NODE_W     = 15;
    localparam int OFF_W      = 14;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_REBUILD = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic [1:0] REG_PAGE_COUNT = 2'd0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [14:0] request_pages;
        logic [13:0] free_offset;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] block_offset;
        logic [14:0] block_pages;
        logic [14:0] free_total;
    } rsp_word_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [NODE_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_cmd_t;

    // Smallest power of two that is not below x, for x up to 32768.
    function automatic logic [15:0] round_pow2(input logic [15:0] x);
        logic [15:0] p;
        p = 16'd1;
        for (int k = 0; k < 15; k++)
        begin
            if ((16'd1 << k) < x)
            begin
                p = 16'd1 << (k + 1);
            end
        end
        return p;
    endfunction

endpackage

// ----- hdl/bpa_ram.sv -----
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/bpa_engine.sv -----
module bpa_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  bpa_pkg::req_word_t         req_word,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output bpa_pkg::rsp_word_t         rsp_word,
    input  logic [14:0]                page_count,
    output bpa_pkg::mem_cmd_t          mem_cmd,
    input  logic [bpa_pkg::NODE_W-1:0] mem_rdata
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FILL  = 7'b0000010,
        S_MARK  = 7'b0000100,
        S_DOWN  = 7'b0001000,
        S_CLIMB = 7'b0010000,
        S_UP    = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [bpa_pkg::ADDR_W-1:0] h_reg, h_next;
    logic [14:0] node_reg, node_next;
    logic [14:0] cur_reg, cur_next;
    logic [15:0] p_reg, p_next;
    logic [13:0] off_reg, off_next;
    logic [14:0] span_reg, span_next;
    logic [14:0] marked_reg, marked_next;
    logic [14:0] limit_reg, limit_next;
    logic [14:0] free_reg, free_next;
    logic [14:0] root_reg, root_next;
    logic [1:0]  status_reg, status_next;
    logic [13:0] boff_reg, boff_next;
    logic [14:0] bpages_reg, bpages_next;
    logic        rsp_valid_reg, rsp_valid_next;
    bpa_pkg::rsp_word_t rsp_word_reg, rsp_word_next;

    logic        accept;
    logic [14:0] clamp_n;
    logic [14:0] new_span;
    logic [14:0] excess;
    logic [14:0] new_marked;
    logic [14:0] req_n;
    logic [15:0] req_p;
    logic [14:0] parent_node;
    logic [15:0] pair_sum;
    logic [14:0] merged;
    logic [bpa_pkg::ADDR_W-1:0] parent_h;
    logic [bpa_pkg::ADDR_W-1:0] left_h;
    logic [bpa_pkg::ADDR_W-1:0] right_h;
    logic [15:0] fill_last;
    logic [14:0] climb_mask;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    always_comb
    begin
        if (page_count == 15'd0)
        begin
            clamp_n = 15'd1;
        end
        else if (page_count > 15'(bpa_pkg::MAX_PAGES))
        begin
            clamp_n = 15'(bpa_pkg::MAX_PAGES);
        end
        else
        begin
            clamp_n = page_count;
        end
    end

    assign new_span   = 15'(bpa_pkg::round_pow2({1'b0, clamp_n}));
    assign excess     = new_span - clamp_n;
    assign new_marked = (excess != 15'd0) ? 15'(bpa_pkg::round_pow2({1'b0, excess})) : 15'd0;
    assign req_n      = (req_word.request_pages == 15'd0) ? 15'd1 : req_word.request_pages;
    assign req_p      = bpa_pkg::round_pow2({1'b0, req_n});

    // One merge step of the upward walk: a parent whose two halves are both
    // wholly free becomes one free block, otherwise it takes the larger half.
    assign parent_node = {node_reg[13:0], 1'b0};
    assign pair_sum    = {1'b0, cur_reg} + {1'b0, mem_rdata};
    assign merged      = (pair_sum == {1'b0, parent_node}) ? parent_node
                       : ((cur_reg > mem_rdata) ? cur_reg : mem_rdata);
    assign parent_h    = h_reg >> 1;
    assign left_h      = {h_reg[bpa_pkg::ADDR_W-2:0], 1'b0};
    assign right_h     = left_h + bpa_pkg::ADDR_W'(1);
    assign fill_last   = {span_reg, 1'b0} - 16'd1;
    assign climb_mask  = ~(node_reg - 15'd1);

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        p_next         = p_reg;
        off_next       = off_reg;
        span_next      = span_reg;
        marked_next    = marked_reg;
        limit_next     = limit_reg;
        free_next      = free_reg;
        root_next      = root_reg;
        status_next    = status_reg;
        boff_next      = boff_reg;
        bpages_next    = bpages_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        mem_cmd.we     = 1'b0;
        mem_cmd.waddr  = h_reg;
        mem_cmd.wdata  = 15'd0;
        mem_cmd.raddr  = h_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = bpa_pkg::ST_OK;
                    boff_next   = 14'd0;
                    bpages_next = 15'd0;
                    state_next  = S_DONE;
                    case (req_word.mode)
                        bpa_pkg::MODE_REBUILD:
                        begin
                            span_next   = new_span;
                            marked_next = new_marked;
                            limit_next  = new_span - new_marked;
                            free_next   = new_span - new_marked;
                            h_next      = bpa_pkg::ADDR_W'(1);
                            node_next   = new_span;
                            state_next  = S_FILL;
                        end
                        bpa_pkg::MODE_ALLOC:
                        begin
                            if (req_p > {1'b0, root_reg} || req_p > {1'b0, span_reg})
                            begin
                                status_next = bpa_pkg::ST_NO_FIT;
                            end
                            else
                            begin
                                p_next        = req_p;
                                h_next        = bpa_pkg::ADDR_W'(1);
                                node_next     = span_reg;
                                off_next      = 14'd0;
                                mem_cmd.raddr = bpa_pkg::ADDR_W'(2);
                                state_next    = S_DOWN;
                            end
                        end
                        bpa_pkg::MODE_FREE:
                        begin
                            if ({1'b0, req_word.free_offset} >= limit_reg ||
                                {1'b0, req_word.free_offset} >= span_reg)
                            begin
                                status_next = bpa_pkg::ST_BAD_FREE;
                            end
                            else
                            begin
                                off_next      = req_word.free_offset;
                                h_next        = bpa_pkg::ADDR_W'({1'b0, req_word.free_offset}
                                                + span_reg);
                                mem_cmd.raddr = bpa_pkg::ADDR_W'({1'b0, req_word.free_offset}
                                                + span_reg);
                                node_next     = 15'd1;
                                state_next    = S_CLIMB;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_FILL:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = h_reg;
                mem_cmd.wdata = node_reg;
                if (h_reg == bpa_pkg::ADDR_W'(1))
                begin
                    root_next = node_reg;
                end
                // The block size halves after the last node of each level.
                if ((h_reg & (h_reg + bpa_pkg::ADDR_W'(1))) == '0)
                begin
                    node_next = node_reg >> 1;
                end
                h_next = h_reg + bpa_pkg::ADDR_W'(1);
                if ({1'b0, h_reg} == fill_last)
                begin
                    if (marked_reg == 15'd0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        h_next     = bpa_pkg::ADDR_W'(1);
                        node_next  = span_reg;
                        state_next = S_MARK;
                    end
                end
            end

            S_MARK:
            begin
                if (node_reg == marked_reg)
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = h_reg;
                    mem_cmd.wdata = 15'd0;
                    mem_cmd.raddr = h_reg ^ bpa_pkg::ADDR_W'(1);
                    cur_next      = 15'd0;
                    state_next    = S_UP;
                end
                else
                begin
                    h_next    = left_h + bpa_pkg::ADDR_W'(1);
                    node_next = node_reg >> 1;
                end
            end

            S_DOWN:
            begin
                if ({1'b0, node_reg} == p_reg)
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = h_reg;
                    mem_cmd.wdata = 15'd0;
                    mem_cmd.raddr = h_reg ^ bpa_pkg::ADDR_W'(1);
                    free_next     = free_reg - node_reg;
                    boff_next     = off_reg;
                    bpages_next   = node_reg;
                    cur_next      = 15'd0;
                    if (h_reg == bpa_pkg::ADDR_W'(1))
                    begin
                        root_next  = 15'd0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_UP;
                    end
                end
                else
                begin
                    // The word read is the left child; go right when it is too small.
                    node_next = node_reg >> 1;
                    if ({1'b0, mem_rdata} >= p_reg)
                    begin
                        h_next        = left_h;
                        mem_cmd.raddr = {left_h[bpa_pkg::ADDR_W-2:0], 1'b0};
                    end
                    else
                    begin
                        h_next        = right_h;
                        off_next      = off_reg + 14'(node_reg >> 1);
                        mem_cmd.raddr = {right_h[bpa_pkg::ADDR_W-2:0], 1'b0};
                    end
                end
            end

            S_CLIMB:
            begin
                if (mem_rdata != 15'd0)
                begin
                    if (h_reg == bpa_pkg::ADDR_W'(1))
                    begin
                        status_next = bpa_pkg::ST_BAD_FREE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        h_next        = parent_h;
                        node_next     = parent_node;
                        mem_cmd.raddr = parent_h;
                    end
                end
                else
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = h_reg;
                    mem_cmd.wdata = node_reg;
                    mem_cmd.raddr = h_reg ^ bpa_pkg::ADDR_W'(1);
                    free_next     = free_reg + node_reg;
                    boff_next     = off_reg & climb_mask[13:0];
                    bpages_next   = node_reg;
                    cur_next      = node_reg;
                    if (h_reg == bpa_pkg::ADDR_W'(1))
                    begin
                        root_next  = node_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_UP;
                    end
                end
            end

            S_UP:
            begin
                // The sibling word is in; the parent is written while the
                // next sibling is read.
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = parent_h;
                mem_cmd.wdata = merged;
                mem_cmd.raddr = parent_h ^ bpa_pkg::ADDR_W'(1);
                h_next        = parent_h;
                node_next     = parent_node;
                cur_next      = merged;
                if (parent_h == bpa_pkg::ADDR_W'(1))
                begin
                    root_next  = merged;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_word_next.status       = status_reg;
                    rsp_word_next.block_offset = boff_reg;
                    rsp_word_next.block_pages  = bpages_reg;
                    rsp_word_next.free_total   = free_reg;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            span_reg      <= 15'(bpa_pkg::MAX_PAGES);
            marked_reg    <= 15'd0;
            limit_reg     <= 15'd0;
            free_reg      <= 15'd0;
            root_reg      <= 15'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            span_reg      <= span_next;
            marked_reg    <= marked_next;
            limit_reg     <= limit_next;
            free_reg      <= free_next;
            root_reg      <= root_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg        <= h_next;
        node_reg     <= node_next;
        cur_reg      <= cur_next;
        p_reg        <= p_next;
        off_reg      <= off_next;
        status_reg   <= status_next;
        boff_reg     <= boff_next;
        bpages_reg   <= bpages_next;
        rsp_word_reg <= rsp_word_next;
    end

endmodule

// ----- hdl/buddy_page_allocator_top.sv -----
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_stall  mode, request_pages, free_offset
// rsp       out        rsp_valid / rsp_stall  status, block_offset, block_pages, free_total
// apb       in         psel / penable         page_count at address 0
//
// One item at a time. Allocate walks down the tree level by level and back up
// through the single-read tree memory; free climbs to the allocated node and
// merges back to the root. Rebuild sweeps the tree memory one node a cycle,
// then marks the excess block if there is one. The tree is undefined after
// reset until a rebuild word. A result waits in the output register under
// rsp_stall while the next word is already taken.
module buddy_page_allocator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bpa_pkg::req_word_t  req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bpa_pkg::rsp_word_t  rsp_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [14:0] page_count_reg, page_count_next;
    bpa_pkg::mem_cmd_t          mem_cmd;
    logic [bpa_pkg::NODE_W-1:0] mem_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr == bpa_pkg::REG_PAGE_COUNT) ? {17'd0, page_count_reg} : 32'd0;

    always_comb
    begin
        page_count_next = page_count_reg;
        if (psel && penable && pwrite && paddr == bpa_pkg::REG_PAGE_COUNT)
        begin
            page_count_next = pwdata[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg <= 15'd16384;
        end
        else
        begin
            page_count_reg <= page_count_next;
        end
    end

    bpa_ram #(
        .WIDTH (bpa_pkg::NODE_W),
        .DEPTH (bpa_pkg::TREE_DEPTH)
    ) u_tree (
        .clk   (clk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr),
        .wdata (mem_cmd.wdata),
        .raddr (mem_cmd.raddr),
        .rdata (mem_rdata)
    );

    bpa_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_word   (req_word),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word),
        .page_count (page_count_reg),
        .mem_cmd    (mem_cmd),
        .mem_rdata  (mem_rdata)
    );

endmodule

// ----- sim/buddy_page_allocator_top_tb.sv -----
module buddy_page_allocator_top_tb;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int TREE_NODES = 2 * bpa_pkg::MAX_PAGES - 1;
    localparam int CYCLE_LIMIT = 2000000;

    // Buddy tree predictor and the queue of result words still owed by the block.
    class buddy_scoreboard;
        int unsigned        largest[TREE_NODES];
        int unsigned        span;
        int unsigned        free_cnt;
        int unsigned        managed;
        int unsigned        page_cnt;
        bpa_pkg::rsp_word_t owed[$];
        int                 errors;

        function new();
            span = bpa_pkg::MAX_PAGES;
            free_cnt = 0;
            managed = 0;
            page_cnt = 16384;
            errors = 0;
            foreach (largest[i]) largest[i] = 0;
        endfunction

        function int unsigned pow2_ceil(int unsigned x);
            int unsigned p;
            p = 1;
            while (p < x) p = p << 1;
            return p;
        endfunction

        function void lift(int unsigned idx);
            int unsigned l;
            int unsigned r;
            while (idx != 0)
            begin
                idx = (idx - 1) / 2;
                l = largest[2 * idx + 1];
                r = largest[2 * idx + 2];
                largest[idx] = (l > r) ? l : r;
            end
        endfunction

        function void set_page_count(logic [31:0] v);
            page_cnt = v & 32'h7fff;
        endfunction

        function void regrow();
            int unsigned n;
            int unsigned marked;
            int unsigned total;
            int unsigned sz;
            int unsigned idx;
            n = page_cnt;
            if (n == 0) n = 1;
            if (n > bpa_pkg::MAX_PAGES) n = bpa_pkg::MAX_PAGES;
            span = pow2_ceil(n);
            marked = (span > n) ? pow2_ceil(span - n) : 0;
            total = 2 * span - 1;
            sz = span * 2;
            for (int unsigned i = 0; i < total; i++)
            begin
                if (((i + 1) & i) == 0) sz = sz / 2;
                largest[i] = sz;
            end
            if (marked != 0)
            begin
                idx = 0;
                while (idx < total && largest[idx] != marked) idx = 2 * idx + 2;
                if (idx < total)
                begin
                    largest[idx] = 0;
                    lift(idx);
                end
            end
            free_cnt = span - marked;
            managed = span - marked;
        endfunction

        function bpa_pkg::rsp_word_t note_word(bpa_pkg::req_word_t w);
            bpa_pkg::rsp_word_t e;
            int unsigned        p;
            int unsigned        idx;
            int unsigned        sz;
            int unsigned        off;
            int unsigned        l;
            int unsigned        r;
            bit                 found;
            e = '0;
            if (w.mode == bpa_pkg::MODE_REBUILD)
            begin
                regrow();
            end
            else if (w.mode == bpa_pkg::MODE_ALLOC)
            begin
                p = pow2_ceil((w.request_pages == 0) ? 1 : w.request_pages);
                if (p > largest[0] || p > span)
                begin
                    e.status = bpa_pkg::ST_NO_FIT;
                end
                else
                begin
                    idx = 0;
                    sz = span;
                    while (sz > p)
                    begin
                        if (2 * idx + 1 >= TREE_NODES) break;
                        idx = (largest[2 * idx + 1] >= p) ? 2 * idx + 1 : 2 * idx + 2;
                        sz = sz / 2;
                    end
                    largest[idx] = 0;
                    e.block_offset = 14'((idx + 1) * sz - span);
                    e.block_pages = 15'(sz);
                    lift(idx);
                    free_cnt -= p;
                end
            end
            else if (w.mode == bpa_pkg::MODE_FREE)
            begin
                off = w.free_offset;
                if (off >= managed || off >= span)
                begin
                    e.status = bpa_pkg::ST_BAD_FREE;
                end
                else
                begin
                    idx = off + span - 1;
                    sz = 1;
                    found = 1;
                    while (largest[idx] != 0)
                    begin
                        if (idx == 0)
                        begin
                            found = 0;
                            break;
                        end
                        idx = (idx - 1) / 2;
                        sz = sz * 2;
                    end
                    if (!found)
                    begin
                        e.status = bpa_pkg::ST_BAD_FREE;
                    end
                    else
                    begin
                        largest[idx] = sz;
                        free_cnt += sz;
                        e.block_pages = 15'(sz);
                        e.block_offset = 14'((idx + 1) * sz - span);
                        // Merge buddies on the way back to the root.
                        while (idx != 0)
                        begin
                            idx = (idx - 1) / 2;
                            sz = sz * 2;
                            l = largest[2 * idx + 1];
                            r = largest[2 * idx + 2];
                            largest[idx] = (l + r == sz) ? sz : ((l > r) ? l : r);
                        end
                    end
                end
            end
            e.free_total = 15'(free_cnt);
            owed.push_back(e);
            return e;
        endfunction

        function void check_word(bpa_pkg::rsp_word_t got);
            bpa_pkg::rsp_word_t e;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.status !== e.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.block_offset !== e.block_offset)
            begin
                $display("%0t: block_offset expected %0d got %0d", $time,
                         e.block_offset, got.block_offset);
                errors++;
            end
            if (got.block_pages !== e.block_pages)
            begin
                $display("%0t: block_pages expected %0d got %0d", $time,
                         e.block_pages, got.block_pages);
                errors++;
            end
            if (got.free_total !== e.free_total)
            begin
                $display("%0t: free_total expected %0d got %0d", $time,
                         e.free_total, got.free_total);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    bpa_pkg::req_word_t req_word;
    logic               rsp_valid;
    logic               rsp_stall;
    bpa_pkg::rsp_word_t rsp_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    buddy_scoreboard sb;
    int          gap_pct;
    int          stall_pct;
    int          cycles;
    int unsigned live_off[$];
    int unsigned live_pages[$];

    buddy_page_allocator_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall) sb.check_word(rsp_word);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("buddy_page_allocator_top test failed");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] mode, input int unsigned pages,
                             input int unsigned off);
        bpa_pkg::req_word_t w;
        bpa_pkg::rsp_word_t e;
        int                 k;
        w.mode = mode;
        w.request_pages = 15'(pages);
        w.free_offset = 14'(off);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            req_word <= bpa_pkg::req_word_t'(31'($urandom));
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_word <= w;
        do @(posedge clk); while (req_stall);
        e = sb.note_word(w);
        if (mode == bpa_pkg::MODE_REBUILD)
        begin
            live_off.delete();
            live_pages.delete();
        end
        else if (mode == bpa_pkg::MODE_ALLOC && e.status == bpa_pkg::ST_OK)
        begin
            live_off.push_back(e.block_offset);
            live_pages.push_back(e.block_pages);
        end
        else if (mode == bpa_pkg::MODE_FREE && e.status == bpa_pkg::ST_OK)
        begin
            k = -1;
            foreach (live_off[i]) if (live_off[i] == e.block_offset) k = i;
            if (k >= 0)
            begin
                live_off.delete(k);
                live_pages.delete(k);
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic apb_write(input logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bpa_pkg::REG_PAGE_COUNT;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_page_count(v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_word();
        int          r;
        int          k;
        int unsigned lg;
        lg = $clog2(sb.span);
        r = $urandom_range(99);
        if (r >= 45 && r < 75 && live_off.size() == 0) r = 0;
        if (r < 45)
        begin
            send_word(bpa_pkg::MODE_ALLOC, $urandom_range(1, 1 << $urandom_range(0, lg)),
                      $urandom);
        end
        else if (r < 75)
        begin
            k = $urandom_range(live_off.size() - 1);
            send_word(bpa_pkg::MODE_FREE, $urandom,
                      live_off[k] + $urandom_range(live_pages[k] - 1));
        end
        else if (r < 80)
        begin
            send_word(bpa_pkg::MODE_FREE, $urandom, $urandom_range(16383));
        end
        else if (r < 86)
        begin
            send_word(bpa_pkg::MODE_ALLOC, $urandom_range(32767), $urandom);
        end
        else if (r < 91)
        begin
            send_word(MODE_NOP, $urandom, $urandom);
        end
        else if (r < 94 && sb.span <= 1024)
        begin
            send_word(bpa_pkg::MODE_REBUILD, $urandom, $urandom);
        end
        else
        begin
            send_word(bpa_pkg::MODE_ALLOC, 0, $urandom);
        end
    endtask

    int unsigned sizes[12] = '{13, 16384, 1, 1000, 0, 32767, 16383, 5, 200, 3000, 64, 7777};
    int          gaps[4]   = '{0, 71, 0, 14};
    int          stalls[4] = '{0, 0, 71, 14};

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_word = '0;
        rsp_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gap_pct = 0;
        stall_pct = 0;
        cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 12; ph++)
        begin
            drain();
            apb_write(sizes[ph]);
            gap_pct = gaps[ph % 4];
            stall_pct = stalls[ph % 4];
            send_word(bpa_pkg::MODE_REBUILD, $urandom, $urandom);
            if (ph == 0)
            begin
                // Thirteen pages: span 16, the top four pages are the excess block.
                send_word(bpa_pkg::MODE_ALLOC, 1, 0);
                send_word(bpa_pkg::MODE_ALLOC, 0, 16383);
                send_word(bpa_pkg::MODE_ALLOC, 3, 0);
                send_word(bpa_pkg::MODE_ALLOC, 16384, 0);
                send_word(bpa_pkg::MODE_ALLOC, 32767, 0);
                send_word(bpa_pkg::MODE_ALLOC, 16, 0);
                send_word(bpa_pkg::MODE_FREE, 0, 12);
                send_word(bpa_pkg::MODE_FREE, 0, 16383);
                send_word(bpa_pkg::MODE_FREE, 0, 9);
                send_word(bpa_pkg::MODE_FREE, 0, 6);
                send_word(MODE_NOP, 32767, 16383);
                send_word(bpa_pkg::MODE_FREE, 0, 0);
                send_word(bpa_pkg::MODE_FREE, 0, 1);
                send_word(bpa_pkg::MODE_ALLOC, 8, 0);
                send_word(bpa_pkg::MODE_ALLOC, 4, 0);
                send_word(bpa_pkg::MODE_FREE, 0, 0);
                send_word(bpa_pkg::MODE_REBUILD, 0, 0);
            end
            repeat (85) random_word();
        end
        drain();
        if (sb.errors == 0)
        begin
            $display("buddy_page_allocator_top test passed");
        end
        else
        begin
            $display("buddy_page_allocator_top test failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_engine.sv
hdl/buddy_page_allocator_top.sv
sim/buddy_page_allocator_top_tb.sv
